@@ hdl/catmull_rom_spline_eval_defines.svh @@
// Assertion helpers shared by the RTL; every use samples on i_clk and is
// disabled while i_rst_n is low.
`ifndef CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH

// Same-cycle implication.
`define CRSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CRSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/crse_pkg.sv @@
package crse_pkg;

    // Store geometry
    localparam int MAX_KNOTS  = 32;
    localparam int KNOT_IDX_W = $clog2(MAX_KNOTS);
    localparam int BANKS      = 4;
    localparam int BANK_SEL_W = $clog2(BANKS);
    localparam int BANK_DEPTH = MAX_KNOTS / BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // Field widths
    localparam int KC_W   = 6;
    localparam int POS_W  = 17;
    localparam int KNOT_W = 30;
    localparam int CV_W   = 32;
    localparam int FRAC_W = 16;

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = CV_W;
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + KNOT_IDX_W;
    localparam int POS_LSB   = VAL_LSB + KNOT_W;

    // Datapath widths
    localparam int SEG_W      = KNOT_IDX_W;
    localparam int SCALED_W   = POS_W + SEG_W;
    localparam int SPAN_RAW_W = SCALED_W - FRAC_W;
    // Past the end x stays below 2^16 * (MAX_KNOTS - 2).
    localparam int X_W        = FRAC_W + $clog2(MAX_KNOTS - 2);
    localparam int C_W        = KNOT_W + 3;
    localparam int TAIL_W     = KNOT_W + 1;
    localparam int P1_W       = X_W + 1 + C_W;
    localparam int T1_W       = P1_W - FRAC_W + 1;
    localparam int A_W        = X_W + 1 + T1_W;
    localparam int B_W        = CV_W + FRAC_W;

    localparam int NSTAGE = 6;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

    typedef logic signed [KNOT_W-1:0] t_knot;

    typedef struct packed {
        logic                  en;
        logic [KNOT_IDX_W-1:0] idx;
        t_knot                 value;
    } t_knot_wr;

    typedef struct packed {
        logic                           en;
        logic [BANKS-1:0][BANK_AW-1:0] addr;
    } t_knot_rd;

    // Number of spans (n - 3) with n saturated to 4..MAX_KNOTS.
    function automatic logic [SEG_W-1:0] seg_count(input logic [KC_W-1:0] kc);
        logic [KC_W:0] n;
        n = {1'b0, kc};
        if (n < (KC_W+1)'(4)) begin
            n = (KC_W+1)'(4);
        end else if (n > (KC_W+1)'(MAX_KNOTS)) begin
            n = (KC_W+1)'(MAX_KNOTS);
        end
        return SEG_W'(n - (KC_W+1)'(3));
    endfunction

endpackage

@@ hdl/catmull_rom_spline_eval.sv @@
// Catmull-Rom evaluator over up to 32 signed 30-bit knots. A transfer with
// tuser = 0 writes knot i_s_tdata[34:5] into slot i_s_tdata[4:0] and makes no
// result; a transfer with tuser = 1 evaluates the curve at the 1.16 position
// i_s_tdata[51:35] (65536 is the end, larger positions extrapolate the last
// span) and returns one 32-bit signed value on the master side. The datapath
// is a six-stage pipeline: one item is taken every cycle while o_s_tready is
// high, and evaluation results leave on the master side in input order.
// Throughput is set by the pipeline registers alone; back-pressure on
// i_m_tready fills the stages one by one before o_s_tready drops. Knots are
// written at the input transfer, so an evaluate item right after a write
// already sees that knot. The store is four banks of eight entries read in
// parallel; reading a slot never written gives an undefined value. Write
// i_cfg_wdata (knot count, saturated to 4..32) only while the block is idle.
`include "catmull_rom_spline_eval_defines.svh"

module catmull_rom_spline_eval (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [crse_pkg::KC_W-1:0]      i_cfg_wdata,   // knot_count
    // Slave side
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [crse_pkg::S_TDATA_W-1:0] i_s_tdata,     // knot_index[4:0], knot_value[34:5],
                                                          // position[51:35], zero pad
    input  logic                           i_s_tuser,     // cmd
    // Master side
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [crse_pkg::M_TDATA_W-1:0] o_m_tdata      // curve_value
);

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic [crse_pkg::NSTAGE:1] r_vld;
    logic [crse_pkg::NSTAGE:1] w_rdy;
    logic                      w_s_acc;
    logic                      w_wr_acc;
    logic                      w_ev_acc;
    crse_pkg::t_cmd            w_cmd;

    assign w_cmd    = crse_pkg::t_cmd'(i_s_tuser);
    assign w_s_acc  = i_s_tvalid && o_s_tready;
    assign w_wr_acc = w_s_acc && (w_cmd == crse_pkg::CMD_WRITE);
    assign w_ev_acc = w_s_acc && (w_cmd == crse_pkg::CMD_EVAL);

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        w_rdy[crse_pkg::NSTAGE] = !r_vld[crse_pkg::NSTAGE] || i_m_tready;
        for (int k = crse_pkg::NSTAGE - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            // Only evaluate items travel down the pipe; writes finish at entry.
            if (w_rdy[1]) begin
                r_vld[1] <= i_s_tvalid && (w_cmd == crse_pkg::CMD_EVAL);
            end
            for (int k = 2; k <= crse_pkg::NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[1];
    assign o_m_tvalid = r_vld[crse_pkg::NSTAGE];

    // ------------------------------------------------------------------
    // Configuration: keep the span count n - 3 ready for stage 1
    // ------------------------------------------------------------------
    logic [crse_pkg::SEG_W-1:0] r_segs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segs <= crse_pkg::seg_count(crse_pkg::KC_W'(4));
        end else if (i_cfg_we) begin
            r_segs <= crse_pkg::seg_count(i_cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Knot store
    // ------------------------------------------------------------------
    crse_pkg::t_knot_wr w_wr;
    crse_pkg::t_knot_rd w_rd;
    crse_pkg::t_knot    w_rd_data [crse_pkg::BANKS];

    always_comb begin
        w_wr.idx   = i_s_tdata[crse_pkg::VAL_LSB-1:crse_pkg::IDX_LSB];
        w_wr.value = crse_pkg::t_knot'(i_s_tdata[crse_pkg::POS_LSB-1:crse_pkg::VAL_LSB]);
        // Drop writes beyond the store.
        w_wr.en    = w_wr_acc
                     && ((crse_pkg::KNOT_IDX_W+1)'(w_wr.idx)
                         < (crse_pkg::KNOT_IDX_W+1)'(crse_pkg::MAX_KNOTS));
    end

    crse_knot_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: position register; find span and local fraction
    // ------------------------------------------------------------------
    logic [crse_pkg::POS_W-1:0]      r_pos1;
    logic [crse_pkg::SCALED_W-1:0]   w_scaled;
    logic [crse_pkg::SPAN_RAW_W-1:0] w_span_raw;
    logic [crse_pkg::SEG_W-1:0]      w_span;
    logic [crse_pkg::X_W-1:0]        n_x2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_pos1 <= i_s_tdata[crse_pkg::POS_LSB+crse_pkg::POS_W-1:crse_pkg::POS_LSB];
        end
    end

    always_comb begin
        w_scaled   = crse_pkg::SCALED_W'(r_pos1) * crse_pkg::SCALED_W'(r_segs);
        w_span_raw = w_scaled[crse_pkg::SCALED_W-1:crse_pkg::FRAC_W];
        // Clamp to the last span; past the end x grows beyond one.
        if (w_span_raw >= crse_pkg::SPAN_RAW_W'(r_segs)) begin
            w_span = r_segs - crse_pkg::SEG_W'(1);
        end else begin
            w_span = crse_pkg::SEG_W'(w_span_raw);
        end
        n_x2 = crse_pkg::X_W'(w_scaled
                              - (crse_pkg::SCALED_W'(w_span) << crse_pkg::FRAC_W));
    end

    // Bank b supplies the one knot of span..span+3 that is congruent to b.
    always_comb begin
        logic [crse_pkg::BANK_SEL_W-1:0] off;
        logic [crse_pkg::KNOT_IDX_W-1:0] idx;
        w_rd.en = w_rdy[2];
        for (int b = 0; b < crse_pkg::BANKS; b++) begin
            off = crse_pkg::BANK_SEL_W'(b) - w_span[crse_pkg::BANK_SEL_W-1:0];
            idx = crse_pkg::KNOT_IDX_W'(w_span) + crse_pkg::KNOT_IDX_W'(off);
            w_rd.addr[b] = idx[crse_pkg::KNOT_IDX_W-1:crse_pkg::BANK_SEL_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: knots arrive from the banks; form the cubic coefficients
    // ------------------------------------------------------------------
    logic [crse_pkg::X_W-1:0]        r_x2;
    logic [crse_pkg::BANK_SEL_W-1:0] r_rot2;
    crse_pkg::t_knot                 w_k [crse_pkg::BANKS];
    logic signed [crse_pkg::C_W-1:0] w_e0, w_e1, w_e2, w_e3;
    logic signed [crse_pkg::C_W-1:0] w_h1, w_h2, w_h3, w_nh0;
    logic signed [crse_pkg::C_W-1:0] n_c1, n_c2;
    logic signed [crse_pkg::TAIL_W-1:0] n_tail;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_x2   <= n_x2;
            r_rot2 <= w_span[crse_pkg::BANK_SEL_W-1:0];
        end
    end

    always_comb begin
        // Undo the bank rotation: k[j] is knot span + j.
        for (int j = 0; j < crse_pkg::BANKS; j++) begin
            w_k[j] = w_rd_data[crse_pkg::BANK_SEL_W'(r_rot2 + crse_pkg::BANK_SEL_W'(j))];
        end
        w_e0  = crse_pkg::C_W'(w_k[0]);
        w_e1  = crse_pkg::C_W'(w_k[1]);
        w_e2  = crse_pkg::C_W'(w_k[2]);
        w_e3  = crse_pkg::C_W'(w_k[3]);
        // Floor halves; ~k0 is -k0 - 1.
        w_h1  = w_e1 >>> 1;
        w_h2  = w_e2 >>> 1;
        w_h3  = w_e3 >>> 1;
        w_nh0 = (~w_e0) >>> 1;
        n_c1  = w_h1 - w_h2 - w_e2 + w_e1 + w_h3 + w_nh0;
        n_c2  = (w_e2 <<< 1) - (w_e1 <<< 1) - w_h1 - w_h3 + w_e0;
        n_tail = crse_pkg::TAIL_W'(w_h2 + w_nh0);
    end

    // ------------------------------------------------------------------
    // Stage 3: t1 = floor(x * c1 / 2^16) + c2
    // ------------------------------------------------------------------
    logic signed [crse_pkg::C_W-1:0]    r_c1_3, r_c2_3;
    logic signed [crse_pkg::TAIL_W-1:0] r_tail3;
    crse_pkg::t_knot                    r_k1_3;
    logic [crse_pkg::X_W-1:0]           r_x3;
    logic signed [crse_pkg::P1_W-1:0]   w_p1;
    logic signed [crse_pkg::T1_W-1:0]   n_t1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_c1_3  <= n_c1;
            r_c2_3  <= n_c2;
            r_tail3 <= n_tail;
            r_k1_3  <= w_k[1];
            r_x3    <= r_x2;
        end
    end

    always_comb begin
        w_p1 = $signed({1'b0, r_x3}) * r_c1_3;
        n_t1 = crse_pkg::T1_W'(w_p1 >>> crse_pkg::FRAC_W) + crse_pkg::T1_W'(r_c2_3);
    end

    // ------------------------------------------------------------------
    // Stage 4: b = (x * t1 >> 16) + tail, kept modulo 2^48
    // ------------------------------------------------------------------
    logic signed [crse_pkg::T1_W-1:0]   r_t1_4;
    logic signed [crse_pkg::TAIL_W-1:0] r_tail4;
    crse_pkg::t_knot                    r_k1_4;
    logic [crse_pkg::X_W-1:0]           r_x4;
    logic signed [crse_pkg::A_W-1:0]    w_a;
    logic [crse_pkg::B_W-1:0]           n_b;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_t1_4  <= n_t1;
            r_tail4 <= r_tail3;
            r_k1_4  <= r_k1_3;
            r_x4    <= r_x3;
        end
    end

    always_comb begin
        w_a = $signed({1'b0, r_x4}) * r_t1_4;
        // Only the low 32 result bits matter, so the rest may wrap.
        n_b = crse_pkg::B_W'(w_a >>> crse_pkg::FRAC_W) + crse_pkg::B_W'(r_tail4);
    end

    // ------------------------------------------------------------------
    // Stage 5: value = (x * b >> 16) + k1, low 32 bits
    // ------------------------------------------------------------------
    logic [crse_pkg::B_W-1:0]  r_b5;
    crse_pkg::t_knot           r_k1_5;
    logic [crse_pkg::X_W-1:0]  r_x5;
    logic [crse_pkg::B_W-1:0]  w_c;
    logic [crse_pkg::CV_W-1:0] n_out;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_b5   <= n_b;
            r_k1_5 <= r_k1_4;
            r_x5   <= r_x4;
        end
    end

    always_comb begin
        w_c   = crse_pkg::B_W'(r_x5) * r_b5;
        n_out = w_c[crse_pkg::B_W-1:crse_pkg::FRAC_W] + crse_pkg::CV_W'(r_k1_5);
    end

    // ------------------------------------------------------------------
    // Stage 6: output register, holds while the master side stalls
    // ------------------------------------------------------------------
    logic [crse_pkg::CV_W-1:0] r_out6;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_out6 <= n_out;
        end
    end

    assign o_m_tdata = r_out6;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic w_hold2;

    assign w_hold2 = r_vld[2] && !w_rdy[3];

    `CRSE_ASSERT_NEXT(a_write_no_issue, w_wr_acc, !r_vld[1], "write item entered the pipe")
    `CRSE_ASSERT_NEXT(a_eval_issue, w_ev_acc, r_vld[1], "evaluate item lost at entry")
    `CRSE_ASSERT_NOW(a_stall_only_when_full, !o_s_tready, r_vld[1] && !w_rdy[2], "stall with room")
    `CRSE_ASSERT_NEXT(a_knot_hold, w_hold2, $stable(w_k[0]) && $stable(w_k[3]), "knots lost")

endmodule

@@ hdl/crse_knot_store.sv @@
module crse_knot_store (
    input  logic               i_clk,
    input  crse_pkg::t_knot_wr i_wr,
    input  crse_pkg::t_knot_rd i_rd,
    output crse_pkg::t_knot    o_rd_data [crse_pkg::BANKS]
);

    // Knot i lives in bank i mod BANKS, so four neighbors hit four banks.
    for (genvar b = 0; b < crse_pkg::BANKS; b++) begin : g_bank
        crse_pkg::t_knot r_mem [crse_pkg::BANK_DEPTH];
        crse_pkg::t_knot r_rd;
        logic            w_hit;

        assign w_hit = i_wr.en
                       && (i_wr.idx[crse_pkg::BANK_SEL_W-1:0] == crse_pkg::BANK_SEL_W'(b));

        always_ff @(posedge i_clk) begin
            if (w_hit) begin
                r_mem[i_wr.idx[crse_pkg::KNOT_IDX_W-1:crse_pkg::BANK_SEL_W]] <= i_wr.value;
            end
        end

        // Hold read data while the consuming stage stalls.
        always_ff @(posedge i_clk) begin
            if (i_rd.en) begin
                r_rd <= r_mem[i_rd.addr[b]];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

@@ sim/catmull_rom_spline_eval_tb.sv @@
`timescale 1ns / 100ps

module catmull_rom_spline_eval_tb;
    import crse_pkg::*;

    localparam int   DRAIN_CYCLES = 12;    // pipeline depth plus margin
    localparam int   QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
    localparam int   SINK_HOLD    = 150;   // long receiver hold-off
    localparam int   PHASE_ITEMS  = 130;
    localparam t_knot KNOT_MIN    = {1'b1, {(KNOT_W-1){1'b0}}};
    localparam t_knot KNOT_MAX    = {1'b0, {(KNOT_W-1){1'b1}}};

    // Tracks the knot store and knot count as the block should see them and
    // holds the curve values still owed by the block, oldest first.
    class curve_ledger;
        int unsigned knots_in_use;
        longint      knots[MAX_KNOTS];
        logic [CV_W-1:0] pending_curve[$];
        int          errors;

        function new();
            set_count(KC_W'(4));
            foreach (knots[i]) knots[i] = 0;
            errors = 0;
        endfunction

        // Saturate the count to the range the block supports.
        function void set_count(logic [KC_W-1:0] kc);
            knots_in_use = kc;
            if (knots_in_use < 4) knots_in_use = 4;
            if (knots_in_use > MAX_KNOTS) knots_in_use = MAX_KNOTS;
        endfunction

        function int outstanding();
            return pending_curve.size();
        endfunction

        // Catmull-Rom value at a 1.16 position, low 32 bits.
        function logic [CV_W-1:0] curve_at(logic [POS_W-1:0] pos);
            int unsigned segs, span;
            bit [63:0]   scaled, x, a, b, c, r;
            longint      k0, k1, k2, k3, c1, c2, tail, t1;
            segs   = knots_in_use - 3;
            scaled = 64'(pos) * 64'(segs);
            span   = int'(scaled >> FRAC_W);
            // Past the end: stay in the last span and let x grow.
            if (span >= segs) span = knots_in_use - 4;
            x  = scaled - 64'(span) * 64'd65536;
            k0 = knots[span];
            k1 = knots[span + 1];
            k2 = knots[span + 2];
            k3 = knots[span + 3];
            // Arithmetic shifts on signed values floor, as the block does.
            c1   = (k1 >>> 1) - (k2 >>> 1) - k2 + k1 + (k3 >>> 1) + ((-k0 - 1) >>> 1);
            c2   = 2 * k2 - 2 * k1 - (k1 >>> 1) - (k3 >>> 1) + k0;
            tail = (k2 >>> 1) + ((-k0 - 1) >>> 1);
            t1   = ((longint'(x) * c1) >>> FRAC_W) + c2;
            // Only the low result bits matter from here on, so wrap mod 2^64.
            a = x * $unsigned(t1);
            b = (a >> FRAC_W) + $unsigned(tail);
            c = x * b;
            r = (c >> FRAC_W) + $unsigned(k1);
            return r[CV_W-1:0];
        endfunction

        // Apply an accepted input transfer.
        function void take_item(t_cmd cmd, logic [S_TDATA_W-1:0] data);
            if (cmd == CMD_WRITE) begin
                knots[data[IDX_LSB +: KNOT_IDX_W]] = $signed(data[VAL_LSB +: KNOT_W]);
            end else begin
                pending_curve.push_back(curve_at(data[POS_LSB +: POS_W]));
            end
        endfunction

        // Compare an accepted result with the oldest owed value.
        function void check_curve(logic [CV_W-1:0] got);
            logic [CV_W-1:0] want;
            if (pending_curve.size() == 0) begin
                $error("curve_value: nothing expected, actual %0d", $signed(got));
                errors++;
            end else begin
                want = pending_curve.pop_front();
                if (want !== got) begin
                    $error("curve_value: expected %0d, actual %0d",
                           $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [KC_W-1:0]      i_cfg_wdata;   // knot_count
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;     // knot_index, knot_value, position, zero pad
    logic                 i_s_tuser;     // cmd
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;     // curve_value

    curve_ledger ledger = new();
    bit          calm       = 1'b0;  // no idling on either side
    bit          stall_sink = 1'b0;  // ask the receiver for one long hold-off
    int          quiet_cycles = 0;

    catmull_rom_spline_eval u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sample both sides at the rising edge. Check results before noting the
    // new input: a result never belongs to an item taken in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) ledger.check_curve(o_m_tdata);
            if (i_s_tvalid && o_s_tready) ledger.take_item(t_cmd'(i_s_tuser), i_s_tdata);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("catmull_rom_spline_eval_tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: random ready bursts, long ready stretches, one long hold-off.
    initial begin
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stall_sink) begin
                i_m_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge i_clk);
                stall_sink = 1'b0;
            end else if (calm || $urandom_range(0, 5) != 0) begin
                i_m_tready <= 1'b1;
                if (calm) begin
                    @(negedge i_clk);
                end else if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(40, 120)) @(negedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                end
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the transfer.
    task automatic send_item(t_cmd cmd, logic [KNOT_IDX_W-1:0] idx, t_knot val,
                             logic [POS_W-1:0] pos);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{(S_TDATA_W - POS_W - KNOT_W - KNOT_IDX_W){1'b0}}, pos, val, idx};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic idle_sender(int cycles);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Drop valid and wait until every owed curve value has come back.
    task automatic drain_results();
        idle_sender(1);
        while (ledger.outstanding() != 0) @(negedge i_clk);
    endtask

    // Change the knot count only with the pipeline empty; writes leave no
    // trace on the output, so let a few more cycles pass first.
    task automatic write_knot_count(logic [KC_W-1:0] kc);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kc;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_count(kc);
    endtask

    function automatic t_knot pick_knot();
        case ($urandom_range(0, 9))
            0:       return KNOT_MIN;
            1:       return KNOT_MAX;
            2, 3:    return t_knot'($urandom_range(0, 4000)) - t_knot'(2000);
            default: return t_knot'($urandom);
        endcase
    endfunction

    // Mostly inside the curve, with span edges and extrapolation mixed in.
    function automatic logic [POS_W-1:0] pick_position();
        int segs;
        segs = int'(ledger.knots_in_use) - 3;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return POS_W'(65536);
            2:       return '1;
            3, 4:    return POS_W'((65536 * $urandom_range(0, segs)) / segs
                                   + $urandom_range(0, 2) - 1);
            5, 6, 7: return POS_W'($urandom_range(65537, 131071));
            default: return POS_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_eval(logic [POS_W-1:0] pos);
        // Index and value bits are don't-care for an evaluation; randomize them.
        send_item(CMD_EVAL, KNOT_IDX_W'($urandom), t_knot'($urandom), pos);
    endtask

    task automatic send_write(logic [KNOT_IDX_W-1:0] idx, t_knot val);
        send_item(CMD_WRITE, idx, val, POS_W'($urandom));
    endtask

    initial begin
        logic [KC_W-1:0] phase_counts[10];

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = CMD_WRITE;
        i_s_tdata   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: four knots at alternating extremes so the cubic wraps,
        // then the curve ends, the exact end point and extrapolation.
        send_write(0, KNOT_MIN);
        send_write(1, KNOT_MAX);
        send_write(2, KNOT_MIN);
        send_write(3, KNOT_MAX);
        send_eval(0);
        send_eval(1);
        send_eval(32768);
        send_eval(65535);
        send_eval(65536);
        send_eval(65537);
        send_eval('1);
        // Modest knots, checked right behind their writes.
        send_write(0, 1000);
        send_write(1, -3);
        send_write(2, 70000);
        send_write(3, -1);
        send_eval(0);
        send_eval(49152);
        send_eval(65536);
        // A count below the minimum saturates to four knots.
        write_knot_count(0);
        send_eval(98304);
        send_eval(16384);
        send_write(31, KNOT_MAX);

        // Load every slot so any later count reads written knots only.
        for (int i = 0; i < MAX_KNOTS; i++) send_write(KNOT_IDX_W'(i), pick_knot());

        phase_counts = '{6'd32, 6'd63, 6'd0, 6'd17, 6'd33, 6'd5, 6'd31, 6'd3, 6'd4, 6'd0};
        phase_counts[9] = KC_W'($urandom_range(0, 63));

        for (int p = 0; p < 10; p++) begin
            write_knot_count(phase_counts[p]);
            // Run the last phase flat out on both sides.
            if (p == 9) calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 40) begin
                    // Keep offering evaluations through the hold-off so the
                    // pipeline fills and the input stalls.
                    stall_sink = 1'b1;
                    while (stall_sink) send_eval(pick_position());
                end
                if (p == 5 && i == 60) drain_results();
                if (!calm && $urandom_range(0, 9) == 0) idle_sender($urandom_range(1, 17));
                if ($urandom_range(0, 9) < 3) begin
                    send_write(KNOT_IDX_W'($urandom), pick_knot());
                end else begin
                    send_eval(pick_position());
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (ledger.outstanding() != 0) begin
            $error("curve_value: %0d results never arrived", ledger.outstanding());
            ledger.errors++;
        end
        if (ledger.errors == 0) begin
            $display("catmull_rom_spline_eval_tb: done, clean");
        end else begin
            $display("catmull_rom_spline_eval_tb: done, errors");
        end
        $finish;
    end

endmodule
